// ----- rtl/core/rlpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rlpf_pkg
// Types, register indexes and saturation helpers shared by the lift blocks.
// ----------------------------------------------------------------------------
package rlpf_pkg;

   typedef enum logic [1:0] {
      MODE_DISABLED = 2'd0,
      MODE_UP       = 2'd1,
      MODE_DOWN     = 2'd2
   } lift_mode_type;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_LIFT_ON  = 2'd1,
      OP_LIFT_OFF = 2'd2,
      OP_ANCHOR   = 2'd3
   } opcode_type;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_STEP     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_STEP   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_HEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KP          = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KD_PER_TICK = 3'd5;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [30:0]        up_step;
      logic [30:0]        down_step;
      logic signed [31:0] max_height;
      logic signed [31:0] min_height;
      logic [30:0]        kp;
      logic [30:0]        kd_per_tick;
   } cfg_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } s1_type;

   typedef struct packed {
      logic               active;
      lift_mode_type      mode;
      logic signed [31:0] err;
      logic signed [32:0] derr;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } s2_type;

   typedef struct packed {
      logic               active;
      lift_mode_type      mode;
      logic signed [63:0] prod_p;
      logic signed [63:0] prod_d;
      logic signed [63:0] prod_x;
      logic signed [63:0] prod_y;
   } s3_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] == v[31]) begin
         r = v[31:0];
      end else begin
         r = v[32] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
      logic signed [31:0] r;
      if ((&v[64:31]) || !(|v[64:31])) begin
         r = v[31:0];
      end else begin
         r = v[64] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/rlpf_state.sv -----
// ----------------------------------------------------------------------------
// rlpf_state
// Lift mode machine, target ramp, height error and position deltas; holds the tick state.
// ----------------------------------------------------------------------------
module rlpf_state (
   input  logic             clock,
   input  logic             reset,
   input  rlpf_pkg::cfg_type cfg,
   input  rlpf_pkg::s1_type  s1,
   input  logic             step,
   output rlpf_pkg::s2_type  s2
);
   import rlpf_pkg::*;

   lift_mode_type      mode_ff, mode_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [31:0] last_x_ff, last_x_in;
   logic signed [31:0] last_y_ff, last_y_in;
   logic signed [31:0] last_z_ff, last_z_in;
   s2_type             s2_ff, s2_in;

   logic signed [31:0] t_up_sat, t_up, t_dn, t_new, err;

   assign t_up_sat = sat33(33'(target_ff) + $signed({2'b00, cfg.up_step}));
   assign t_up     = (t_up_sat > cfg.max_height) ? cfg.max_height : t_up_sat;
   assign t_dn     = sat33(33'(target_ff) - $signed({2'b00, cfg.down_step}));
   assign t_new    = (mode_ff == MODE_UP) ? t_up : t_dn;
   assign err      = sat33(33'(t_new) - 33'(s1.pos_z));

   always_comb begin
      mode_in     = mode_ff;
      target_in   = target_ff;
      last_err_in = last_err_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      last_z_in   = last_z_ff;
      s2_in.active = 1'b0;
      unique case (s1.opcode)
         OP_TICK: begin
            last_x_in = s1.pos_x;
            last_y_in = s1.pos_y;
            last_z_in = s1.pos_z;
            if (mode_ff == MODE_UP || mode_ff == MODE_DOWN) begin
               s2_in.active = 1'b1;
               target_in    = t_new;
               last_err_in  = err;
               if (mode_ff == MODE_DOWN && t_dn < cfg.min_height) begin
                  mode_in = MODE_DISABLED;
               end
            end else begin
               last_err_in = '0;
            end
         end
         OP_LIFT_ON: begin
            if (mode_ff != MODE_UP) begin
               mode_in = MODE_UP;
               if (mode_ff != MODE_DOWN) begin
                  target_in = last_z_ff;
               end
            end
         end
         OP_LIFT_OFF: begin
            if (mode_ff == MODE_UP) begin
               mode_in = MODE_DOWN;
            end
         end
         OP_ANCHOR: begin
            target_in   = s1.pos_z;
            last_x_in   = s1.pos_x;
            last_y_in   = s1.pos_y;
            last_z_in   = s1.pos_z;
            last_err_in = '0;
         end
      endcase
      s2_in.mode = mode_in;
      s2_in.err  = err;
      s2_in.derr = 33'(err) - 33'(last_err_ff);
      s2_in.dx   = 33'(s1.pos_x) - 33'(last_x_ff);
      s2_in.dy   = 33'(s1.pos_y) - 33'(last_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DISABLED;
         target_ff   <= '0;
         last_err_ff <= '0;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         last_z_ff   <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         target_ff   <= target_in;
         last_err_ff <= last_err_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
         last_z_ff   <= last_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

// ----- rtl/core/rlpf_mult.sv -----
// ----------------------------------------------------------------------------
// rlpf_mult
// Gain products for the vertical PD term and the horizontal damping.
// ----------------------------------------------------------------------------
module rlpf_mult (
   input  logic             clock,
   input  rlpf_pkg::cfg_type cfg,
   input  rlpf_pkg::s2_type  s2,
   input  logic             step,
   output rlpf_pkg::s3_type  s3
);
   import rlpf_pkg::*;

   logic signed [31:0] kp_s, kd_s;
   logic signed [63:0] pp_full;
   logic signed [64:0] pd_full, px_full, py_full;
   s3_type             s3_ff, s3_in;

   assign kp_s    = $signed({1'b0, cfg.kp});
   assign kd_s    = $signed({1'b0, cfg.kd_per_tick});
   assign pp_full = 64'(s2.err) * 64'(kp_s);
   assign pd_full = 65'(s2.derr) * 65'(kd_s);
   assign px_full = 65'(s2.dx) * 65'(kd_s);
   assign py_full = 65'(s2.dy) * 65'(kd_s);

   always_comb begin
      s3_in.active = s2.active;
      s3_in.mode   = s2.mode;
      s3_in.prod_p = pp_full;
      s3_in.prod_d = pd_full[63:0];
      s3_in.prod_x = px_full[63:0];
      s3_in.prod_y = py_full[63:0];
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

// ----- rtl/core/rlpf_out.sv -----
// ----------------------------------------------------------------------------
// rlpf_out
// Sums, floors and saturates the products into the result register.
// ----------------------------------------------------------------------------
module rlpf_out (
   input  logic              clock,
   input  rlpf_pkg::s3_type   s3,
   input  logic              step,
   output logic signed [31:0] force_x,
   output logic signed [31:0] force_y,
   output logic signed [31:0] force_z,
   output logic              apply_force,
   output logic [1:0]        lift_mode
);
   import rlpf_pkg::*;

   logic signed [64:0] sum_z, neg_x, neg_y;
   logic signed [31:0] fx, fy, fz;
   logic signed [31:0] force_x_ff, force_y_ff, force_z_ff;
   logic               apply_ff;
   lift_mode_type      mode_ff;

   assign sum_z = 65'(s3.prod_p) + 65'(s3.prod_d);
   assign neg_x = -65'(s3.prod_x);
   assign neg_y = -65'(s3.prod_y);
   assign fz    = s3.active ? sat65(sum_z >>> 16) : '0;
   assign fx    = s3.active ? sat65(neg_x >>> 16) : '0;
   assign fy    = s3.active ? sat65(neg_y >>> 16) : '0;

   always_ff @(posedge clock) begin
      if (step) begin
         force_x_ff <= fx;
         force_y_ff <= fy;
         force_z_ff <= fz;
         apply_ff   <= s3.active && !fz[31] && (|fz);
         mode_ff    <= s3.mode;
      end
   end

   assign force_x     = force_x_ff;
   assign force_y     = force_y_ff;
   assign force_z     = force_z_ff;
   assign apply_force = apply_ff;
   assign lift_mode   = mode_ff;

endmodule

// ----- rtl/core/ramped_lift_pd_force.sv -----
// ----------------------------------------------------------------------------
// ramped_lift_pd_force
// Ramped lift controller giving PD vertical force and horizontal damping.
//
// req_ carries one transaction per tick: an opcode (tick, lift on, lift off,
// re-anchor) and the measured point. rsp_ returns exactly one result per
// request: forces, apply flag and the lift mode after the step. Both
// channels move a transaction when valid is high and stall is low.
// csr_ writes the six configuration registers; ready is always high and
// writes are expected only while the block is idle.
// A request passes the state/error stage, the gain multiplier stage and the
// result register behind the input register before rsp_valid rises.
// Throughput is one transaction per cycle while rsp_stall is low; the lift
// state is updated in the single stage after the input register, so
// back-to-back ticks chain.
// When rsp_stall is held the pipeline fills and req_stall rises once all
// four stages hold a transaction. Reset clears the lift state, the pipeline
// and the configuration to defaults.
// ----------------------------------------------------------------------------
module ramped_lift_pd_force (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic              rsp_apply_force,
   output logic [1:0]        rsp_lift_mode,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [rlpf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]       csr_data
);
   import rlpf_pkg::*;

   cfg_type cfg_ff;
   s1_type  s1_ff;
   s2_type  s2;
   s3_type  s3;

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic adv1, adv2, adv3, advo;
   logic accept, load2, load3, loado;

   assign advo   = !vo_ff || !rsp_stall;
   assign adv3   = !v3_ff || advo;
   assign adv2   = !v2_ff || adv3;
   assign adv1   = !v1_ff || adv2;
   assign accept = req_valid && adv1;
   assign load2  = v1_ff && adv2;
   assign load3  = v2_ff && adv3;
   assign loado  = v3_ff && advo;

   assign req_stall = !adv1;
   assign rsp_valid = vo_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (advo) vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.opcode <= opcode_type'(req_opcode);
         s1_ff.pos_x  <= req_pos_x;
         s1_ff.pos_y  <= req_pos_y;
         s1_ff.pos_z  <= req_pos_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_step     <= '0;
         cfg_ff.down_step   <= '0;
         cfg_ff.max_height  <= S32_MAX;
         cfg_ff.min_height  <= S32_MIN;
         cfg_ff.kp          <= '0;
         cfg_ff.kd_per_tick <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_UP_STEP:     cfg_ff.up_step     <= csr_data[30:0];
            CSR_DOWN_STEP:   cfg_ff.down_step   <= csr_data[30:0];
            CSR_MAX_HEIGHT:  cfg_ff.max_height  <= csr_data;
            CSR_MIN_HEIGHT:  cfg_ff.min_height  <= csr_data;
            CSR_KP:          cfg_ff.kp          <= csr_data[30:0];
            CSR_KD_PER_TICK: cfg_ff.kd_per_tick <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   rlpf_state u_state (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .s1    (s1_ff),
      .step  (load2),
      .s2    (s2)
   );

   rlpf_mult u_mult (
      .clock (clock),
      .cfg   (cfg_ff),
      .s2    (s2),
      .step  (load3),
      .s3    (s3)
   );

   rlpf_out u_out (
      .clock       (clock),
      .s3          (s3),
      .step        (loado),
      .force_x     (rsp_force_x),
      .force_y     (rsp_force_y),
      .force_z     (rsp_force_z),
      .apply_force (rsp_apply_force),
      .lift_mode   (rsp_lift_mode)
   );

`ifndef ASSERT_OFF
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && vo_ff))
      else $error("request stalled with a free pipeline stage");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !adv2) |=> (v1_ff && $stable(s1_ff)))
      else $error("blocked input register lost its transaction");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v3_ff))
      else $error("result appeared without a transaction behind it");
`endif

endmodule
